// File: rtl/percent_decode_stream_top_defines.svh
// Shared assertion macros for the percent decoder.
`ifndef PERCENT_DECODE_STREAM_TOP_DEFINES_SVH
`define PERCENT_DECODE_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define PDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define PDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pds_pkg.sv
`timescale 1ns / 1ps
package pds_pkg;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_DIG  = 2'd2;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] ALPHA_BASE = 8'd10;
  localparam logic [7:0] NOT_DIGIT  = 8'hFF;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       error;
  } pds_res_t;

  // 0..35 for a digit or letter, all ones for anything else
  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    if (b >= CH_0 && b <= CH_9) begin
      v = b - CH_0;
    end else if (b >= CH_UA && b <= CH_UZ) begin
      v = b - CH_UA + ALPHA_BASE;
    end else if (b >= CH_LA && b <= CH_LZ) begin
      v = b - CH_LA + ALPHA_BASE;
    end else begin
      v = NOT_DIGIT;
    end
    return v;
  endfunction

endpackage

// File: rtl/pds_decode.sv
`timescale 1ns / 1ps
`include "percent_decode_stream_top_defines.svh"
module pds_decode
  import pds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output pds_res_t   res
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] dv;

  assign dv = digit_value(in_byte);

  always_comb begin
    phase_nxt = PH_IDLE;
    high_nxt  = high_r;
    res.valid = 1'b1;
    res.data  = in_byte;
    res.last  = in_last;
    res.error = 1'b0;
    case (phase_r)
      PH_PCT: begin
        if (in_last) begin
          res.data  = '0;
          res.error = 1'b1;
        end else begin
          res.valid = 1'b0;
          high_nxt  = dv[3:0];
          phase_nxt = PH_DIG;
        end
      end
      PH_DIG: begin
        res.data = {high_r, 4'h0} | dv;
      end
      default: begin
        if (in_byte == CH_PERCENT) begin
          if (in_last) begin
            res.data  = '0;
            res.error = 1'b1;
          end else begin
            res.valid = 1'b0;
            phase_nxt = PH_PCT;
          end
        end else if (in_byte == CH_PLUS) begin
          res.data = CH_SPACE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
    end
  end

  `PDS_ASSERT_NXT(a_last_ends_escape, accept && in_last, phase_r == PH_IDLE, "escape open after last")
  `PDS_ASSERT_NXT(a_pct_opens, accept && phase_r == PH_IDLE && in_byte == CH_PERCENT && !in_last, phase_r == PH_PCT, "percent did not open escape")
  `PDS_ASSERT_IMP(a_err_only_in_escape, accept && res.valid && res.error, in_last && (phase_r == PH_PCT || in_byte == CH_PERCENT), "error outside cut escape")

endmodule

// File: rtl/percent_decode_stream_top.sv
`timescale 1ns / 1ps
`include "percent_decode_stream_top_defines.svh"
// Streaming URI percent decoder. Takes one byte per cycle while in_stall is
// low, with in_last on the final byte of a string; '+' becomes a space, "%XY"
// becomes one byte, other bytes pass. The '%' and first digit of an escape
// give no result. A string that ends inside an escape yields one result with
// out_error set, out_byte 0 and out_last set. One request per cycle is
// sustained while out_stall is low, set by a single decode stage ahead of an
// output register with a one-entry skid buffer.
module percent_decode_stream_top
  import pds_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_error
);

  logic     accept;
  pds_res_t res;
  pds_res_t out_r, out_nxt;
  pds_res_t skid_r, skid_nxt;

  assign in_stall = skid_r.valid;
  assign accept   = in_valid && !in_stall;

  pds_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .res     (res)
  );

  always_comb begin
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (out_r.valid && out_stall) begin
      if (accept && res.valid) begin
        skid_nxt = res;
      end
    end else if (skid_r.valid) begin
      out_nxt        = skid_r;
      skid_nxt.valid = 1'b0;
    end else begin
      out_nxt       = res;
      out_nxt.valid = accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid  <= 1'b0;
      skid_r.valid <= 1'b0;
    end else begin
      out_r.valid  <= out_nxt.valid;
      skid_r.valid <= skid_nxt.valid;
    end
    out_r.data   <= out_nxt.data;
    out_r.last   <= out_nxt.last;
    out_r.error  <= out_nxt.error;
    skid_r.data  <= skid_nxt.data;
    skid_r.last  <= skid_nxt.last;
    skid_r.error <= skid_nxt.error;
  end

  assign out_valid = out_r.valid;
  assign out_byte  = out_r.data;
  assign out_last  = out_r.last;
  assign out_error = out_r.error;

  `PDS_ASSERT_IMP(a_skid_behind_out, skid_r.valid, out_r.valid, "skid holds data with output empty")
  `PDS_ASSERT_IMP(a_err_format, out_r.valid && out_r.error, out_r.data == '0 && out_r.last, "bad error result")
  `PDS_ASSERT_NXT(a_skid_drains, out_r.valid && !out_stall && skid_r.valid, out_r.valid && !skid_r.valid, "skid did not drain")

endmodule

// File: bench/tb_percent_decode_stream_top.sv
`timescale 1ns / 1ps
module tb_percent_decode_stream_top;
  import pds_pkg::*;

  localparam int DIRECTED_MAX = 25;
  localparam int RANDOM_BYTES = 850;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } enc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       error;
  } dec_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  enc_t enc_q[$];
  dec_t decoded_q[$];

  // decoder state as predicted
  logic [1:0] esc_ph = PH_IDLE;
  logic [7:0] hi_nib = 8'h00;

  int mismatches = 0;
  int bytes_sent = 0;
  int results_ok = 0;
  int cut_short  = 0;
  int strings    = 0;
  int cycles     = 0;
  int gap_left   = 0;
  int hold_left  = 0;
  bit tx_idle    = 1'b1;
  bit rx_idle    = 1'b1;

  percent_decode_stream_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_error (out_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 0..35 for an alphanumeric, all ones otherwise
  function automatic logic [7:0] char_weight(input logic [7:0] c);
    logic [7:0] v;
    v = 8'hFF;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      v = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      v = c - CH_LA + 8'd10;
    end
    return v;
  endfunction

  task automatic decode_byte(input logic [7:0] c, input logic fin);
    dec_t r;
    logic [11:0] v;
    bit has_res;
    has_res = 1'b1;
    r = '{data: c, last: fin, error: 1'b0};
    case (esc_ph)
      PH_PCT: begin
        esc_ph = PH_IDLE;
        if (fin) begin
          r = '{data: 8'h00, last: 1'b1, error: 1'b1};
        end else begin
          hi_nib = char_weight(c);
          esc_ph = PH_DIG;
          has_res = 1'b0;
        end
      end
      PH_DIG: begin
        v = {hi_nib, 4'h0} | {4'h0, char_weight(c)};
        esc_ph = PH_IDLE;
        r.data = v[7:0];
      end
      default: begin
        esc_ph = PH_IDLE;
        if (c == CH_PERCENT) begin
          if (fin) begin
            r = '{data: 8'h00, last: 1'b1, error: 1'b1};
          end else begin
            esc_ph = PH_PCT;
            has_res = 1'b0;
          end
        end else if (c == CH_PLUS) begin
          r.data = CH_SPACE;
        end
      end
    endcase
    if (has_res) begin
      decoded_q.push_back(r);
    end
  endtask

  task automatic add_byte(input logic [7:0] c, input logic fin);
    enc_t e;
    e.code = c;
    e.fin = fin;
    enc_q.push_back(e);
  endtask

  // mostly hex digits, some other letters, a few arbitrary bytes
  function automatic logic [7:0] pick_digit();
    int r;
    int idx;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      idx = $urandom_range(0, 21);
      if (idx < 10) c = CH_0 + 8'(idx);
      else if (idx < 16) c = CH_UA + 8'(idx - 10);
      else c = CH_LA + 8'(idx - 16);
    end else if (r < 9) begin
      idx = $urandom_range(0, 61);
      if (idx < 10) c = CH_0 + 8'(idx);
      else if (idx < 36) c = CH_UA + 8'(idx - 10);
      else c = CH_LA + 8'(idx - 36);
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // one string, sometimes ending inside an escape
  task automatic add_string();
    logic [7:0] txt[$];
    int n;
    int k;
    int kind;
    n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        txt.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 50) begin
        txt.push_back(CH_PLUS);
      end else begin
        txt.push_back(CH_PERCENT);
        txt.push_back(pick_digit());
        txt.push_back(pick_digit());
      end
    end
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      txt.push_back(CH_PERCENT);
    end else if (kind == 1) begin
      txt.push_back(CH_PERCENT);
      txt.push_back(pick_digit());
    end
    for (k = 0; k < txt.size(); k++) begin
      add_byte(txt[k], k == txt.size() - 1);
    end
  endtask

  // noise: percent-heavy bytes with random end flags
  task automatic add_noise();
    int n;
    int k;
    n = $urandom_range(1, 10);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_PERCENT, $urandom_range(0, 3) == 0);
      end else begin
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  always @(posedge clk) begin : drive_requests
    int gap;
    enc_t e;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        decode_byte(in_byte, in_last);
        bytes_sent++;
        if (in_last) strings++;
        if ($urandom_range(0, 59) == 0) tx_idle = !tx_idle;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
      end else begin
        gap = gap_left;
      end
      if (gap == 0 && enc_q.size() > 0) begin
        e = enc_q.pop_front();
        in_valid <= 1'b1;
        in_byte  <= e.code;
        in_last  <= e.fin;
        gap_left <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= (gap > 0) ? gap - 1 : 0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    dec_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: byte=%h last=%b error=%b",
                     out_byte, out_last, out_error);
          end
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data || out_last !== want.last ||
              out_error !== want.error) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected byte=%h last=%b error=%b,",
                       want.data, want.last, want.error,
                       " got byte=%h last=%b error=%b",
                       out_byte, out_last, out_error);
            end
          end else begin
            results_ok++;
            if (want.error) cut_short++;
          end
        end
        if ($urandom_range(0, 59) == 0) rx_idle = !rx_idle;
        hold_left = rx_idle ? $urandom_range(0, 9) : 0;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** percent_decode_stream_top: FAILED **");
      $finish;
    end
  end

  initial begin
    // extremes passed through, and a plus
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(CH_PLUS, 1'b1);
    // escapes with digits, then with lower and upper case letters
    add_byte(CH_PERCENT, 1'b0); add_byte("4", 1'b0); add_byte("1", 1'b0);
    add_byte(CH_PERCENT, 1'b0); add_byte("z", 1'b0); add_byte("Z", 1'b0);
    // bad first digit, then bad second digit ending the string
    add_byte(CH_PERCENT, 1'b0); add_byte("!", 1'b0); add_byte("5", 1'b0);
    add_byte(CH_PERCENT, 1'b0); add_byte("4", 1'b0); add_byte("~", 1'b1);
    // string ends right after the percent, then after the first digit
    add_byte(CH_PERCENT, 1'b1);
    add_byte(CH_PERCENT, 1'b0); add_byte("7", 1'b1);
    // percent as both digits; letter past F overflowing the high nibble
    add_byte(CH_PERCENT, 1'b0); add_byte(CH_PERCENT, 1'b0); add_byte(CH_PERCENT, 1'b0);
    add_byte(CH_PERCENT, 1'b0); add_byte("G", 1'b0); add_byte("0", 1'b1);
    while (enc_q.size() < DIRECTED_MAX + RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_string();
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (enc_q.size() > 0 || in_valid || decoded_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (decoded_q.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", decoded_q.size());
    end
    $display("sent %0d bytes in %0d ended strings; %0d results matched",
             bytes_sent, strings, results_ok);
    $display("%0d of them flagged strings that ended inside an escape", cut_short);
    if (mismatches == 0) begin
      $display("** percent_decode_stream_top: PASSED **");
    end else begin
      $display("** percent_decode_stream_top: FAILED **");
    end
    $finish;
  end

endmodule
